>>> sv/bis_pkg.sv
// shared types, register indexes and arithmetic helpers for the bilinear scaler
// no dependencies
`timescale 1ns / 1ps

package bis_pkg;

  localparam int unsigned DEF_MAX_SRC_WIDTH  = 256;
  localparam int unsigned DEF_MAX_SRC_HEIGHT = 256;
  localparam int unsigned DEF_MAX_DEST_SIZE  = 4096;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHARP       = 3'd6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [2:0] DEPTH_THREE = 3'd3;

  localparam logic [7:0]  Q8_ONE      = 8'd255;
  localparam logic [15:0] Q8_HALF     = 16'd128;
  localparam int unsigned FRAC_SCALE  = 510;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FRAC,
    ST_READ,
    ST_DRAIN,
    ST_VERT,
    ST_SHARP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       start;
    logic       done;
  } div_ctrl_t;

  // (a*(255-f) + b*f + 128) >> 8
  function automatic logic [7:0] blend8(logic [7:0] a, logic [7:0] b, logic [7:0] f);
    logic [15:0] acc;
    acc = 16'(a) * 16'(Q8_ONE - f) + 16'(b) * 16'(f) + Q8_HALF;
    return acc[15:8];
  endfunction

  // b + (b*k>>8) - (pn*k>>9), clamped to a byte
  function automatic logic [7:0] sharpen8(logic [7:0] b, logic [8:0] pn, logic [7:0] k);
    logic [15:0]        bk;
    logic [16:0]        pk;
    logic signed [10:0] s;
    bk = 16'(b) * 16'(k);
    pk = 17'(pn) * 17'(k);
    s  = $signed({3'b000, b}) + $signed({3'b000, bk[15:8]}) - $signed({3'b000, pk[16:9]});
    if (s < 0) begin
      return 8'd0;
    end else if (s > 11'sd255) begin
      return 8'd255;
    end else begin
      return s[7:0];
    end
  endfunction

endpackage

>>> sv/bis_image_mem.sv
// source image store: one write port, one registered read port
// depends on nothing
`timescale 1ns / 1ps

module bis_image_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bis_divider.sv
// restoring divider, one quotient bit per cycle
// uses bis_pkg for the control struct
`timescale 1ns / 1ps

module bis_divider #(
  parameter int unsigned DV_W = 27,
  parameter int unsigned DS_W = 15
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bis_pkg::div_ctrl_t      ctrl_i,
  input  logic [DV_W-1:0]         dividend_i,
  input  logic [DS_W-1:0]         divisor_i,
  output bis_pkg::div_ctrl_t      ctrl_o,
  output logic [DV_W-1:0]         quot_o,
  output logic [DS_W-1:0]         rem_o
);
  import bis_pkg::*;

  localparam int unsigned CW = $clog2(DV_W);

  logic            busy_q;
  logic [CW-1:0]   cnt_q;
  logic [DV_W-1:0] quot_q;
  logic [DS_W:0]   rem_q;
  logic [DS_W-1:0] div_q;
  logic            done_q;
  logic [DS_W:0]   trial;
  logic            fits;

  assign trial = {rem_q[DS_W-1:0], quot_q[DV_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DV_W-2:0], fits};
      rem_q  <= fits ? (trial - {1'b0, div_q}) : trial;
    end
  end

  assign ctrl_o.start = busy_q;
  assign ctrl_o.done  = done_q;
  assign quot_o       = quot_q;
  assign rem_o        = rem_q[DS_W-1:0];

endmodule

>>> sv/bilinear_image_scaler_sharpen.sv
// bilinear / nearest image scaler with unsharp sharpening, top level
// uses bis_pkg, bis_divider and bis_image_mem; one item at a time
// bilinear request: four divisions plus eight image reads; an axis mapped below zero skips its
// fraction division; nearest request: two divisions and one read, direct copy: one read, outside
// the destination: no read; a new item is accepted only after the result moves to the output register
// reset sets the config and control registers to their defaults; the image store is not cleared
`timescale 1ns / 1ps

module bilinear_image_scaler_sharpen #(
  parameter int unsigned MAX_SRC_WIDTH  = bis_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = bis_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned MAX_DEST_SIZE  = bis_pkg::DEF_MAX_DEST_SIZE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bis_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [55:0]                       s_axis_tdata,  // coord_x[11:0], coord_y[23:12], pixel_in[55:24]
  input  logic                              s_axis_tuser,  // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata,  // pixel_out
  output logic                              m_axis_tuser   // status
);
  import bis_pkg::*;

  localparam int unsigned SW_W  = $clog2(MAX_SRC_WIDTH + 1);
  localparam int unsigned SH_W  = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int unsigned SZ_W  = (SW_W > SH_W) ? SW_W : SH_W;
  localparam int unsigned DW_W  = $clog2(MAX_DEST_SIZE + 1);
  localparam int unsigned XW    = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned IW    = (XW > YW) ? XW : YW;
  localparam int unsigned DV_A  = 13 + SZ_W;
  localparam int unsigned DV_B  = DW_W + 10;
  localparam int unsigned DV_W  = (DV_A > DV_B) ? DV_A : DV_B;
  localparam int unsigned DS_W  = DW_W + 2;
  localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  // configuration registers
  logic [8:0]  src_width_q, src_height_q;
  logic [12:0] dest_width_q, dest_height_q;
  logic        scale_mode_q;
  logic [2:0]  pixel_depth_q;
  logic [7:0]  sharp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= 9'd256;
      src_height_q  <= 9'd256;
      dest_width_q  <= 13'd256;
      dest_height_q <= 13'd256;
      scale_mode_q  <= MODE_BILINEAR;
      pixel_depth_q <= 3'd4;
      sharp_q       <= 8'd64;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SRC_WIDTH:   src_width_q   <= cfg_wdata_i[8:0];
        REG_SRC_HEIGHT:  src_height_q  <= cfg_wdata_i[8:0];
        REG_DEST_WIDTH:  dest_width_q  <= cfg_wdata_i[12:0];
        REG_DEST_HEIGHT: dest_height_q <= cfg_wdata_i[12:0];
        REG_SCALE_MODE:  scale_mode_q  <= cfg_wdata_i[0];
        REG_PIXEL_DEPTH: pixel_depth_q <= cfg_wdata_i[2:0];
        REG_SHARP:       sharp_q       <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // effective sizes clamped into their ranges
  logic [SZ_W-1:0] sw, sh;
  logic [DW_W-1:0] dw, dh;

  assign sw = (src_width_q == '0) ? SZ_W'(1) :
              ((32'(src_width_q) > MAX_SRC_WIDTH) ? SZ_W'(MAX_SRC_WIDTH) : SZ_W'(src_width_q));
  assign sh = (src_height_q == '0) ? SZ_W'(1) :
              ((32'(src_height_q) > MAX_SRC_HEIGHT) ? SZ_W'(MAX_SRC_HEIGHT) :
               SZ_W'(src_height_q));
  assign dw = (dest_width_q == '0) ? DW_W'(1) :
              ((32'(dest_width_q) > MAX_DEST_SIZE) ? DW_W'(MAX_DEST_SIZE) : DW_W'(dest_width_q));
  assign dh = (dest_height_q == '0) ? DW_W'(1) :
              ((32'(dest_height_q) > MAX_DEST_SIZE) ? DW_W'(MAX_DEST_SIZE) :
               DW_W'(dest_height_q));

  logic depth3;
  assign depth3 = pixel_depth_q == DEPTH_THREE;

  // input fields
  logic [11:0] in_x, in_y;
  logic [31:0] in_pix;
  assign in_x   = s_axis_tdata[11:0];
  assign in_y   = s_axis_tdata[23:12];
  assign in_pix = s_axis_tdata[55:24];

  function automatic logic [AW-1:0] pix_addr(logic [IW-1:0] x, logic [IW-1:0] y);
    return AW'(AW'(y) * AW'(MAX_SRC_WIDTH)) + AW'(x);
  endfunction

  // request state
  state_e          state_q, state_d;
  logic [11:0]     cx_q, cy_q;
  logic            simple_q;   // copy or nearest: one read
  logic            nearest_q;
  logic            axis_q;
  logic            pend_q;
  logic            neg_q;
  logic [DV_W-1:0] num_q;
  logic [DS_W-1:0] den_q;
  logic [IW-1:0]   i0_q [2];
  logic [7:0]      f_q [2];
  logic [2:0]      rd_cnt_q;
  logic            rvld_q;
  logic [2:0]      ridx_q;
  logic [31:0]     x0pix_q;
  logic [7:0]      h_q [4][4];
  logic [7:0]      b_q [4];
  logic [8:0]      pn_q [4];
  logic [31:0]     res_q;
  logic            res_status_q;
  logic            out_vld_q;
  logic [31:0]     out_pix_q;
  logic            out_status_q;

  // divider
  div_ctrl_t       div_in, div_out;
  logic [DV_W-1:0] div_quot;
  logic [DS_W-1:0] div_rem;

  bis_divider #(
    .DV_W(DV_W),
    .DS_W(DS_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (div_in),
    .dividend_i(num_q),
    .divisor_i (den_q),
    .ctrl_o    (div_out),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // derived source indices
  logic [IW-1:0] x0, x1, y0, y1, yp, yn;
  logic [IW-1:0] sw_m1, sh_m1;
  assign sw_m1 = IW'(sw - 1'b1);
  assign sh_m1 = IW'(sh - 1'b1);
  assign x0    = i0_q[0];
  assign y0    = i0_q[1];
  assign x1    = (x0 < sw_m1) ? x0 + 1'b1 : sw_m1;
  assign y1    = (y0 < sh_m1) ? y0 + 1'b1 : sh_m1;
  assign yp    = (y0 != '0) ? y0 - 1'b1 : '0;
  assign yn    = (y1 < sh_m1) ? y1 + 1'b1 : sh_m1;

  // axis selected operands
  logic [11:0]     d_sel;
  logic [SZ_W-1:0] s_sel;
  logic [DW_W-1:0] n_sel;
  logic [IW-1:0]   s_sel_m1;
  assign d_sel    = axis_q ? cy_q : cx_q;
  assign s_sel    = axis_q ? sh : sw;
  assign n_sel    = axis_q ? dh : dw;
  assign s_sel_m1 = IW'(s_sel - 1'b1);

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_rdata;
  logic [IW-1:0] rd_x, rd_y;
  logic          s_fire;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign mem_we    = s_fire && (s_axis_tuser == OP_WRITE) &&
                     (32'(in_x) < 32'(sw)) && (32'(in_y) < 32'(sh));
  assign mem_waddr = pix_addr(IW'(in_x), IW'(in_y));

  always_comb begin
    rd_x = rd_cnt_q[0] ? x1 : x0;
    case (rd_cnt_q[2:1])
      2'd0:    rd_y = y0;
      2'd1:    rd_y = y1;
      2'd2:    rd_y = yp;
      default: rd_y = yn;
    endcase
  end
  assign mem_raddr = pix_addr(rd_x, rd_y);

  bis_image_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(in_pix),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // next state and strobes
  logic rd_last;
  logic out_free;
  assign rd_last  = simple_q ? (rd_cnt_q == 3'd0) : (rd_cnt_q == 3'd7);
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    div_in.start  = 1'b0;
    div_in.done   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && s_axis_tuser == OP_READ) begin
          if (32'(in_x) >= 32'(dw) || 32'(in_y) >= 32'(dh)) begin
            state_d = ST_OUT;
          end else if (32'(sw) == 32'(dw) && 32'(sh) == 32'(dh)) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV, ST_FRAC: begin
        div_in.start = !pend_q;
        if (div_out.done) begin
          if (state_q == ST_DIV && !nearest_q && !neg_q) begin
            state_d = ST_FRAC;
          end else if (axis_q) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_READ:  if (rd_last) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_VERT;
      ST_VERT:  state_d = simple_q ? ST_OUT : ST_SHARP;
      ST_SHARP: state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pend_q    <= 1'b0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_in.start) begin
        pend_q <= 1'b1;
      end else if (div_out.done) begin
        pend_q <= 1'b0;
      end
      rvld_q <= state_q == ST_READ;
      if (state_q == ST_OUT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath
  logic [DV_W-1:0] prod_bil, prod_nn;
  logic [IW-1:0]   idx_clamped;
  logic [7:0]      vert [4];
  logic            do_sharp;
  logic [31:0]     sharp_pix;

  assign prod_bil    = DV_W'({d_sel, 1'b1}) * DV_W'(s_sel);
  assign prod_nn     = DV_W'(d_sel) * DV_W'(s_sel);
  assign idx_clamped = (div_quot > DV_W'(s_sel_m1)) ? s_sel_m1 : IW'(div_quot);
  assign do_sharp    = depth3 && (sharp_q != '0) && (y0 != y1);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      vert[c] = (y0 == y1) ? h_q[0][c] : blend8(h_q[0][c], h_q[1][c], f_q[1]);
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sharp_pix[8*c +: 8] = do_sharp ? sharpen8(b_q[c], pn_q[c], sharp_q) : b_q[c];
    end
    if (depth3) begin
      sharp_pix[31:24] = 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cx_q         <= in_x;
        cy_q         <= in_y;
        axis_q       <= 1'b0;
        rd_cnt_q     <= '0;
        nearest_q    <= scale_mode_q == MODE_NEAREST;
        simple_q     <= (scale_mode_q == MODE_NEAREST) ||
                        (32'(sw) == 32'(dw) && 32'(sh) == 32'(dh));
        res_q        <= '0;
        res_status_q <= STATUS_RANGE;
        i0_q[0]      <= IW'(in_x);
        i0_q[1]      <= IW'(in_y);
        f_q[0]       <= '0;
        f_q[1]       <= '0;
      end
      ST_MUL: begin
        if (nearest_q) begin
          num_q <= prod_nn;
          den_q <= DS_W'(n_sel);
        end else begin
          neg_q <= prod_bil < DV_W'(n_sel);
          num_q <= prod_bil - DV_W'(n_sel);
          den_q <= DS_W'({n_sel, 1'b0});
        end
      end
      ST_DIV: begin
        if (div_out.done) begin
          if (nearest_q) begin
            i0_q[axis_q] <= idx_clamped;
            axis_q       <= 1'b1;
          end else if (neg_q) begin
            i0_q[axis_q] <= '0;
            f_q[axis_q]  <= '0;
            axis_q       <= 1'b1;
          end else begin
            i0_q[axis_q] <= idx_clamped;
            num_q        <= DV_W'(DV_W'(div_rem) * DV_W'(FRAC_SCALE)) + DV_W'({n_sel, 1'b0});
            den_q        <= DS_W'({n_sel, 2'b00});
          end
        end
      end
      ST_FRAC: begin
        if (div_out.done) begin
          f_q[axis_q] <= div_quot[7:0];
          axis_q      <= 1'b1;
        end
      end
      ST_READ: rd_cnt_q <= rd_cnt_q + 1'b1;
      ST_VERT: begin
        res_status_q <= STATUS_OK;
        if (simple_q) begin
          res_q <= depth3 ? {8'd0, x0pix_q[23:0]} : x0pix_q;
        end
        for (int c = 0; c < 4; c++) begin
          b_q[c]  <= vert[c];
          pn_q[c] <= 9'(h_q[2][c]) + 9'(h_q[3][c]);
        end
      end
      ST_SHARP: res_q <= sharp_pix;
      default: ;
    endcase

    // read data returns in the cycle after its address
    if (rvld_q) begin
      if (!ridx_q[0]) begin
        x0pix_q <= mem_rdata;
      end else begin
        for (int c = 0; c < 4; c++) begin
          h_q[ridx_q[2:1]][c] <= blend8(x0pix_q[8*c +: 8], mem_rdata[8*c +: 8], f_q[0]);
        end
      end
    end
    ridx_q <= rd_cnt_q;

    if (state_q == ST_OUT && out_free) begin
      out_pix_q    <= res_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tuser  = out_status_q;

endmodule
